// File: rtl/core/slc_pkg.sv
// Shared types and constants for the source line classifier.
package slc_pkg;

    // Default widths of the line counters and the line totals
    localparam int TOTAL_WIDTH_DEF      = 32;
    localparam int LINE_COUNT_WIDTH_DEF = 16;
    // Width of each result field on the ports
    localparam int OUT_WIDTH            = 32;
    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH          = 4;

    // Character codes the decoder looks for
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Byte class produced by the front
    typedef enum logic [2:0] {
        CLS_WS,
        CLS_NL,
        CLS_SLASH,
        CLS_STAR,
        CLS_OTHER
    } t_cls;

    // What the previous byte was, as far as the comment logic cares
    typedef enum logic [1:0] {
        PREV_NONE,
        PREV_SLASH,
        PREV_STAR,
        PREV_NL
    } t_prev;

    // One classified beat in the queue
    typedef struct packed {
        t_cls cls;
        logic fin;
    } t_beat;

    // Queue status seen by the back
    typedef struct packed {
        logic  empty;
        t_beat head;
    } t_qstat;

endpackage

// File: rtl/core/slc_front.sv
// Front: accepts text bytes and reduces each to a byte class.
module slc_front (
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_text_byte,
    input  logic               i_final_byte,
    output logic               o_wr,
    output slc_pkg::t_beat     o_beat
);

    slc_pkg::t_cls cls;

    // Byte decoder
    always_comb begin
        unique case (i_text_byte) inside
            slc_pkg::CH_SP, slc_pkg::CH_TAB, slc_pkg::CH_CR, slc_pkg::CH_NUL: begin
                cls = slc_pkg::CLS_WS;
            end
            slc_pkg::CH_NL:    cls = slc_pkg::CLS_NL;
            slc_pkg::CH_SLASH: cls = slc_pkg::CLS_SLASH;
            slc_pkg::CH_STAR:  cls = slc_pkg::CLS_STAR;
            default:           cls = slc_pkg::CLS_OTHER;
        endcase
    end

    // Accept a beat whenever the queue has room
    assign o_wr       = i_push && !i_full;
    assign o_beat.cls = cls;
    assign o_beat.fin = i_final_byte;

endmodule

// File: rtl/core/slc_queue.sv
// Short queue of classified beats between front and back.
module slc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  slc_pkg::t_beat     i_beat,
    input  logic               i_rd,
    output logic               o_full,
    output slc_pkg::t_qstat    o_stat
);

    localparam int DEPTH = slc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    slc_pkg::t_beat r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (i_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
        end
        case ({i_wr, i_rd})
            2'b10:   n_cnt = CW'(r_cnt + 1'b1);
            2'b01:   n_cnt = CW'(r_cnt - 1'b1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.head  = r_mem[r_rp];

endmodule

// File: rtl/core/slc_back.sv
// Back: per-line state, line totals and the result register.
module slc_back #(
    parameter int TOTAL_WIDTH      = slc_pkg::TOTAL_WIDTH_DEF,
    parameter int LINE_COUNT_WIDTH = slc_pkg::LINE_COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slc_pkg::t_qstat               i_stat,
    output logic                          o_rd,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [slc_pkg::OUT_WIDTH-1:0] o_code_lines,
    output logic [slc_pkg::OUT_WIDTH-1:0] o_empty_lines,
    output logic [slc_pkg::OUT_WIDTH-1:0] o_comment_lines
);

    localparam int TW = TOTAL_WIDTH;
    localparam int LW = LINE_COUNT_WIDTH;
    localparam int OW = slc_pkg::OUT_WIDTH;

    // Line state
    logic [LW-1:0]  r_code_cnt, n_code_cnt, s_code_cnt;
    logic [LW-1:0]  r_vis_cnt, n_vis_cnt, s_vis_cnt;
    logic           r_in_lc, n_in_lc, s_in_lc;
    logic           r_in_bc, n_in_bc, s_in_bc;
    logic           r_touched, n_touched, s_touched;
    slc_pkg::t_prev r_prev, n_prev, s_prev;
    // Totals
    logic [TW-1:0]  r_code_tot, n_code_tot, t_code_tot;
    logic [TW-1:0]  r_empty_tot, n_empty_tot, t_empty_tot;
    logic [TW-1:0]  r_cmt_tot, n_cmt_tot, t_cmt_tot;
    // Result register
    logic           r_out_valid, n_out_valid;
    logic [OW-1:0]  r_out_code, r_out_empty, r_out_cmt;

    logic           take;
    logic           outside;
    logic           fin;
    slc_pkg::t_cls  cls;
    logic [LW-1:0]  code_inc, code_dec, vis_inc;
    logic           do_cls;
    logic [LW-1:0]  c_code, c_vis;
    logic           c_touch;

    assign cls     = i_stat.head.cls;
    assign fin     = i_stat.head.fin;
    // A final beat waits only while the result register holds an unpopped result
    assign take    = !i_stat.empty && (!fin || !r_out_valid || i_pop);
    assign o_rd    = take;
    assign outside = !r_in_lc && !r_in_bc;

    // Saturating line count steps
    assign code_inc = (r_code_cnt == '1) ? r_code_cnt : LW'(r_code_cnt + 1'b1);
    assign code_dec = (r_code_cnt == '0) ? r_code_cnt : LW'(r_code_cnt - 1'b1);
    assign vis_inc  = (r_vis_cnt == '1) ? r_vis_cnt : LW'(r_vis_cnt + 1'b1);

    // Per-byte step of the line state
    always_comb begin
        s_code_cnt = r_code_cnt;
        s_vis_cnt  = r_vis_cnt;
        s_in_lc    = r_in_lc;
        s_in_bc    = r_in_bc;
        s_touched  = r_touched;
        s_prev     = r_prev;
        unique case (cls)
            slc_pkg::CLS_WS: begin
                s_prev = slc_pkg::PREV_NONE;
            end
            slc_pkg::CLS_NL: begin
                s_code_cnt = '0;
                s_vis_cnt  = '0;
                s_in_lc    = 1'b0;
                s_touched  = r_in_bc;
                s_prev     = slc_pkg::PREV_NL;
            end
            slc_pkg::CLS_SLASH: begin
                s_vis_cnt = vis_inc;
                if (outside) begin
                    if (r_prev == slc_pkg::PREV_SLASH) begin
                        s_code_cnt = code_dec;
                        s_in_lc    = 1'b1;
                        s_touched  = 1'b1;
                        s_prev     = slc_pkg::PREV_NONE;
                    end else begin
                        s_code_cnt = code_inc;
                        s_prev     = slc_pkg::PREV_SLASH;
                    end
                end else if (r_in_bc) begin
                    if (r_prev == slc_pkg::PREV_STAR) begin
                        s_in_bc = 1'b0;
                        s_prev  = slc_pkg::PREV_NONE;
                    end else begin
                        s_prev  = slc_pkg::PREV_SLASH;
                    end
                end
            end
            slc_pkg::CLS_STAR: begin
                s_vis_cnt = vis_inc;
                if (outside && r_prev == slc_pkg::PREV_SLASH) begin
                    s_code_cnt = code_dec;
                    s_in_bc    = 1'b1;
                    s_touched  = 1'b1;
                    s_prev     = slc_pkg::PREV_NONE;
                end else begin
                    if (outside) begin
                        s_code_cnt = code_inc;
                    end
                    s_prev = slc_pkg::PREV_STAR;
                end
            end
            default: begin
                if (outside) begin
                    s_code_cnt = code_inc;
                end
                s_vis_cnt = vis_inc;
                s_prev    = slc_pkg::PREV_NONE;
            end
        endcase
    end

    // Line classification: a newline classifies the line before the step,
    // a final byte classifies the open line after the step
    always_comb begin
        if (cls == slc_pkg::CLS_NL) begin
            c_code  = r_code_cnt;
            c_vis   = r_vis_cnt;
            c_touch = r_touched;
        end else begin
            c_code  = s_code_cnt;
            c_vis   = s_vis_cnt;
            c_touch = s_touched;
        end
        do_cls = take && (cls == slc_pkg::CLS_NL || (fin && s_prev != slc_pkg::PREV_NL));

        t_code_tot  = r_code_tot;
        t_empty_tot = r_empty_tot;
        t_cmt_tot   = r_cmt_tot;
        if (do_cls) begin
            if (c_vis <= LW'(1) && r_empty_tot != '1) begin
                t_empty_tot = TW'(r_empty_tot + 1'b1);
            end
            if (c_code > LW'(1) && r_code_tot != '1) begin
                t_code_tot = TW'(r_code_tot + 1'b1);
            end
            if (c_code <= LW'(1) && c_touch && r_cmt_tot != '1) begin
                t_cmt_tot = TW'(r_cmt_tot + 1'b1);
            end
        end
    end

    // Next state: hold, step, or clear everything after a final byte
    always_comb begin
        n_code_cnt  = r_code_cnt;
        n_vis_cnt   = r_vis_cnt;
        n_in_lc     = r_in_lc;
        n_in_bc     = r_in_bc;
        n_touched   = r_touched;
        n_prev      = r_prev;
        n_code_tot  = r_code_tot;
        n_empty_tot = r_empty_tot;
        n_cmt_tot   = r_cmt_tot;
        n_out_valid = r_out_valid && !i_pop;
        if (take) begin
            if (fin) begin
                n_code_cnt  = '0;
                n_vis_cnt   = '0;
                n_in_lc     = 1'b0;
                n_in_bc     = 1'b0;
                n_touched   = 1'b0;
                n_prev      = slc_pkg::PREV_NONE;
                n_code_tot  = '0;
                n_empty_tot = '0;
                n_cmt_tot   = '0;
                n_out_valid = 1'b1;
            end else begin
                n_code_cnt  = s_code_cnt;
                n_vis_cnt   = s_vis_cnt;
                n_in_lc     = s_in_lc;
                n_in_bc     = s_in_bc;
                n_touched   = s_touched;
                n_prev      = s_prev;
                n_code_tot  = t_code_tot;
                n_empty_tot = t_empty_tot;
                n_cmt_tot   = t_cmt_tot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_cnt  <= '0;
            r_vis_cnt   <= '0;
            r_in_lc     <= 1'b0;
            r_in_bc     <= 1'b0;
            r_touched   <= 1'b0;
            r_prev      <= slc_pkg::PREV_NONE;
            r_code_tot  <= '0;
            r_empty_tot <= '0;
            r_cmt_tot   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_code_cnt  <= n_code_cnt;
            r_vis_cnt   <= n_vis_cnt;
            r_in_lc     <= n_in_lc;
            r_in_bc     <= n_in_bc;
            r_touched   <= n_touched;
            r_prev      <= n_prev;
            r_code_tot  <= n_code_tot;
            r_empty_tot <= n_empty_tot;
            r_cmt_tot   <= n_cmt_tot;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded on a final beat
    always_ff @(posedge i_clk) begin
        if (take && fin) begin
            r_out_code  <= OW'(t_code_tot);
            r_out_empty <= OW'(t_empty_tot);
            r_out_cmt   <= OW'(t_cmt_tot);
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_code_lines    = r_out_code;
    assign o_empty_lines   = r_out_empty;
    assign o_comment_lines = r_out_cmt;

endmodule

// File: rtl/core/source_line_classifier_top.sv
// Source line classifier: top level with front, beat queue and back.
// Takes one text byte per cycle while the queue has room and counts code,
// blank and comment-only lines; the byte flagged final closes the text, and one
// beat carrying the three totals then appears on the result side, after which
// all counts restart from zero. The back takes one byte per clock unless a final
// byte waits on an unpopped result. Bytes reach the back through the queue;
// the totals show up the cycle after the final byte is processed.
// The front and back are separated by a four-beat queue, so bytes keep being
// accepted while a result waits; a final byte waits in the queue until the
// previous result has been popped. Totals and per-line counts saturate.
module source_line_classifier_top #(
    parameter int TOTAL_WIDTH      = slc_pkg::TOTAL_WIDTH_DEF,
    parameter int LINE_COUNT_WIDTH = slc_pkg::LINE_COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_final_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [slc_pkg::OUT_WIDTH-1:0] o_code_lines,
    output logic [slc_pkg::OUT_WIDTH-1:0] o_empty_lines,
    output logic [slc_pkg::OUT_WIDTH-1:0] o_comment_lines
);

    logic            wr;
    logic            rd;
    slc_pkg::t_beat  beat;
    slc_pkg::t_qstat qstat;

    // Front: byte decode
    slc_front u_front (
        .i_push       (push),
        .i_full       (full),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_wr         (wr),
        .o_beat       (beat)
    );

    // Beat queue
    slc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_beat  (beat),
        .i_rd    (rd),
        .o_full  (full),
        .o_stat  (qstat)
    );

    // Back: line state and totals
    slc_back #(
        .TOTAL_WIDTH      (TOTAL_WIDTH),
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stat          (qstat),
        .o_rd            (rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_code_lines    (o_code_lines),
        .o_empty_lines   (o_empty_lines),
        .o_comment_lines (o_comment_lines)
    );

`ifndef SYNTHESIS
    // Nothing waits on either side right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue or result not clear after reset");

    // The back stalls only on a final beat blocked by an unpopped result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!qstat.empty && !rd) |-> (qstat.head.fin && !empty && !pop))
        else $error("back stalled without cause");

    // A full queue always has a beat at its head
    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !qstat.empty)
        else $error("queue full and empty at once");

    // A result appears only after a final beat was taken by the back
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(rd && qstat.head.fin))
        else $error("result without final beat");
`endif

endmodule

// File: dv/testbench.sv
// Testbench for the source line classifier: random texts, line-total predictor, result checks.
module testbench;
    import slc_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_BYTES = 840;

    typedef logic [LINE_COUNT_WIDTH_DEF-1:0] t_line_cnt;
    typedef logic [TOTAL_WIDTH_DEF-1:0] t_total;

    // One set of totals as it appears on the result ports
    typedef struct {
        logic [OUT_WIDTH-1:0] code;
        logic [OUT_WIDTH-1:0] blank;
        logic [OUT_WIDTH-1:0] comment;
    } line_totals_t;

    // Line-classification predictor plus the store of totals still owed by the block
    class line_totals_board;
        t_line_cnt code_cnt;
        t_line_cnt vis_cnt;
        bit in_line;
        bit in_block;
        bit touched;
        logic [7:0] prev;
        t_total code_tot;
        t_total blank_tot;
        t_total comment_tot;
        line_totals_t expected_totals[$];
        int errors;

        function new();
            clear_text();
            errors = 0;
        endfunction

        function void clear_text();
            code_cnt = '0;
            vis_cnt = '0;
            in_line = 0;
            in_block = 0;
            touched = 0;
            prev = CH_NUL;
            code_tot = '0;
            blank_tot = '0;
            comment_tot = '0;
        endfunction

        function void bump_code();
            if (code_cnt != '1) code_cnt++;
        endfunction

        function void bump_vis();
            if (vis_cnt != '1) vis_cnt++;
        endfunction

        function void drop_code();
            if (code_cnt != '0) code_cnt--;
        endfunction

        // A line can land in both the blank and the comment total
        function void close_line();
            if (vis_cnt <= 1 && blank_tot != '1) blank_tot++;
            if (code_cnt > 1 && code_tot != '1) code_tot++;
            if (code_cnt <= 1 && touched && comment_tot != '1) comment_tot++;
        endfunction

        // Note one accepted input beat
        function void take_byte(logic [7:0] b, logic fin);
            bit outside;
            line_totals_t r;
            outside = !in_line && !in_block;
            case (b)
                CH_SP, CH_TAB, CH_CR, CH_NUL: prev = b;
                CH_NL: begin
                    close_line();
                    code_cnt = '0;
                    vis_cnt = '0;
                    in_line = 0;
                    touched = in_block;
                    prev = b;
                end
                CH_SLASH: begin
                    bump_vis();
                    if (outside) begin
                        if (prev == CH_SLASH) begin
                            drop_code();
                            in_line = 1;
                            touched = 1;
                            prev = CH_NUL;
                        end else begin
                            bump_code();
                            prev = b;
                        end
                    end else if (in_block) begin
                        if (prev == CH_STAR) begin
                            in_block = 0;
                            prev = CH_NUL;
                        end else begin
                            prev = b;
                        end
                    end
                end
                CH_STAR: begin
                    bump_vis();
                    if (outside && prev == CH_SLASH) begin
                        drop_code();
                        in_block = 1;
                        touched = 1;
                        prev = CH_NUL;
                    end else begin
                        if (outside) bump_code();
                        prev = b;
                    end
                end
                default: begin
                    if (outside) bump_code();
                    bump_vis();
                    prev = b;
                end
            endcase
            // Final byte: close an unterminated last line, emit, restart
            if (fin) begin
                if (prev != CH_NL) close_line();
                r.code = code_tot[OUT_WIDTH-1:0];
                r.blank = blank_tot[OUT_WIDTH-1:0];
                r.comment = comment_tot[OUT_WIDTH-1:0];
                expected_totals = {expected_totals, r};
                clear_text();
            end
        endfunction

        // Compare one accepted result beat with the oldest expected totals
        function void check_totals(logic [OUT_WIDTH-1:0] code, logic [OUT_WIDTH-1:0] blank,
                                   logic [OUT_WIDTH-1:0] comment);
            line_totals_t e;
            if (expected_totals.size() == 0) begin
                $error("result beat with no totals expected");
                errors++;
                return;
            end
            e = expected_totals.pop_front();
            if (code !== e.code) begin
                $error("code_lines: expected %0d, got %0d", e.code, code);
                errors++;
            end
            if (blank !== e.blank) begin
                $error("empty_lines: expected %0d, got %0d", e.blank, blank);
                errors++;
            end
            if (comment !== e.comment) begin
                $error("comment_lines: expected %0d, got %0d", e.comment, comment);
                errors++;
            end
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           i_text_byte;
    logic                 i_final_byte;
    logic                 empty;
    logic                 pop;
    logic [OUT_WIDTH-1:0] o_code_lines;
    logic [OUT_WIDTH-1:0] o_empty_lines;
    logic [OUT_WIDTH-1:0] o_comment_lines;

    line_totals_board sb = new();
    logic [7:0] text_bytes[$];
    int bytes_sent = 0;
    int rx_hold_req = 0;
    int cycle_count = 0;

    source_line_classifier_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .empty          (empty),
        .pop            (pop),
        .o_code_lines   (o_code_lines),
        .o_empty_lines  (o_empty_lines),
        .o_comment_lines(o_comment_lines)
    );

    // Clock and run limit
    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Input side: offer one beat after an idle gap, hold until accepted
    task automatic put_byte(input logic [7:0] b, input logic fin, input int gap);
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_text_byte <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.take_byte(b, fin);
        bytes_sent++;
    endtask

    // Send the staged text with the final flag on its last byte
    task automatic send_text(input int gap_mode);
        int n;
        n = text_bytes.size();
        for (int i = 0; i < n; i++)
            put_byte(text_bytes[i], i == n - 1, (gap_mode == 0) ? 0 : $urandom_range(0, 17));
        text_bytes.delete();
    endtask

    // Drop push and wait for every owed result
    task automatic wait_drained();
        push <= 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Stage one byte at the end of the text
    function void add_byte(logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    function void add_str(string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    // One random token of source text
    function void add_fragment();
        case ($urandom_range(0, 11))
            0, 1: repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(8'h61, 8'h7a)));
            2: begin
                case ($urandom_range(0, 3))
                    0: add_byte(CH_SP);
                    1: add_byte(CH_TAB);
                    2: add_byte(CH_CR);
                    default: add_byte(CH_NUL);
                endcase
            end
            3: begin
                add_str("//");
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(8'h20, 8'h7e)));
            end
            4: add_str("/*");
            5: add_str("*/");
            6: add_byte(CH_SLASH);
            7: add_byte(CH_STAR);
            8: add_byte(8'($urandom_range(0, 255)));
            9: add_byte(CH_NL);
            default: add_byte(8'($urandom_range(8'h30, 8'h7a)));
        endcase
    endfunction

    // Mostly line-structured source, sometimes raw noise
    function void build_random_text();
        int n_lines;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            n_lines = $urandom_range(1, 4);
            for (int l = 0; l < n_lines; l++) begin
                repeat ($urandom_range(0, 6)) add_fragment();
                if (l < n_lines - 1 || $urandom_range(0, 1) == 1) add_byte(CH_NL);
            end
        end
        if (text_bytes.size() == 0) add_byte(8'h61);
    endfunction

    // Result side: random hold-offs, bursts with none, and long holds on request
    initial begin
        int hold;
        int rx_burst;
        rx_burst = 0;
        pop = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_burst > 0) begin
                hold = 0;
                rx_burst--;
            end else begin
                hold = $urandom_range(0, 17);
                if ($urandom_range(0, 9) == 0) rx_burst = $urandom_range(5, 20);
            end
            if (hold > 0) begin
                pop <= 0;
                repeat (hold) @(posedge i_clk);
            end
            pop <= 1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            sb.check_totals(o_code_lines, o_empty_lines, o_comment_lines);
        end
    end

    // Stimulus
    initial begin
        int random_start;
        push = 0;
        i_text_byte = '0;
        i_final_byte = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: lone trailing char, lone newline, line comment, block comment
        // spanning lines with trailing code, whitespace kinds, stray comment closer
        add_str("a");
        send_text(1);
        add_byte(CH_NL);
        send_text(1);
        add_str("//\n");
        send_text(1);
        add_str("/*\n*/b");
        send_text(0);
        add_byte(CH_NUL);
        add_byte(CH_TAB);
        add_byte(CH_CR);
        add_byte(CH_SP);
        add_byte(8'hff);
        send_text(1);
        add_str("a*/b\n");
        send_text(1);

        // Random texts
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            build_random_text();
            send_text($urandom_range(0, 3));
        end
        wait_drained();

        // Back-pressure: receiver holds off while single-byte texts pile up
        rx_hold_req = 300;
        repeat (30) begin
            add_byte(8'($urandom_range(0, 255)));
            send_text(0);
        end
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
